[hdl/bjs_pkg.sv]
// Shared constants and helpers for the bit-vector Jaccard similarity block.
// Used by the top level, the serial divider and the interface checker.
package bjs_pkg;

    // Width of one bitmask word as it travels on the input bus.
    localparam int WORD_W = 64;

    // Number of word bits that the popcount unit takes in one cycle.
    localparam int CHUNK_BITS = 8;

    // Defaults for the top-level parameters.
    localparam int WORD_BITS_DEF     = 64;
    localparam int MAX_WORDS_DEF     = 1048576;
    localparam int FRACTION_BITS_DEF = 16;

    // Population count of one chunk.
    function automatic logic [3:0] popcnt8(input logic [CHUNK_BITS-1:0] x);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            n = n + {3'b000, x[i]};
        end
        return n;
    endfunction

endpackage

[hdl/bjs_div.sv]
// Serial restoring divider that forms the fixed-point ratio num / den.
// One quotient bit per cycle; depends on bjs_pkg only through the import.
module bjs_div
    import bjs_pkg::*;
#(
    parameter int W    = 27,
    parameter int FRAC = FRACTION_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output logic          done,
    output logic [FRAC:0] quotient
);

    localparam int CNT_W = $clog2(FRAC);
    localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;
    logic [FRAC:0]    q_reg;
    logic [W:0]       rem_dbl;
    logic             fits;

    assign rem_dbl = {rem_reg, 1'b0};
    assign fits    = rem_dbl >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                // An empty union gives zero; a ratio of one or more is clamped to one.
                if (den == '0) begin
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end else if (num >= den) begin
                    q_reg    <= ONE;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= num;
                    den_reg  <= den;
                    q_reg    <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                    done_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= W'(rem_dbl - {1'b0, den_reg});
                end else begin
                    rem_reg <= rem_dbl[W-1:0];
                end
                q_reg    <= {q_reg[FRAC-1:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                done_reg <= (cnt_reg == CNT_W'(FRAC - 1));
                if (cnt_reg == CNT_W'(FRAC - 1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[hdl/bitmask_jaccard_similarity_top.sv]
// Bit-vector Jaccard similarity: running popcounts of two sets and their ratio.
// Depends on bjs_pkg and instantiates the serial divider bjs_div.
//
// Usage:
//   Each input transaction on the s_ channel carries one aligned word pair
//   (word_a, word_b) and s_tlast, which marks the final pair of the two sets.
//   The block counts a AND b into an intersection total and a plus b into a
//   count total, both saturating. On the final pair it emits one transaction
//   on the m_ channel with intersection, union and intersection/union as
//   unsigned fixed point with FRACTION_BITS fraction bits, then clears both
//   totals for the next pair of sets.
//   Input: the popcount unit takes 8 word bits per cycle, and s_tready is low
//   while a word pair is counted, so no new pair is taken until the last one
//   has been counted. After the final pair is counted, the block forms the
//   union, starts the serial divider, waits for its quotient (set directly
//   when the union is empty or the ratio is one) and loads the output
//   register. s_tready stays low until the result is loaded.
//   Reset (aresetn low, synchronous) clears both totals and the output valid.
//   If the receiver stalls, the result waits in the output register and the
//   block keeps taking words of the next sets; only a second result waits
//   until the first has been taken.
module bitmask_jaccard_similarity_top
    import bjs_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEF,
    parameter int MAX_WORDS     = MAX_WORDS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int unsigned INTER_MAX = MAX_WORDS * WORD_BITS,
    localparam int INTER_W     = $clog2(INTER_MAX + 1),
    localparam int SIM_W       = FRACTION_BITS + 1,
    localparam int OUT_BITS    = 2 * INTER_W + SIM_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0 up: word_a, word_b.
    input  logic [2*WORD_W-1:0]    s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0 up: intersection_count, union_count, similarity, zero fill.
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int unsigned COUNT_MAX = 2 * INTER_MAX;
    localparam int COUNT_W = $clog2(COUNT_MAX + 1);
    localparam int CHUNKS  = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CHUNK_CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam logic [WORD_W-1:0]  WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - WORD_BITS);
    localparam logic [INTER_W:0]   INTER_LIM = (INTER_W + 1)'(INTER_MAX);
    localparam logic [COUNT_W:0]   COUNT_LIM = (COUNT_W + 1)'(COUNT_MAX);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COUNT = 3'd1;
    localparam logic [2:0] ST_UNION = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [WORD_W-1:0]      a_reg, b_reg;
    logic                   last_reg;
    logic [CHUNK_CW-1:0]    chunk_reg;
    logic [INTER_W-1:0]     inter_reg, inter_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [INTER_W-1:0]     union_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic [3:0]             pc_and, pc_a, pc_b;
    logic [INTER_W:0]       inter_sum;
    logic [COUNT_W:0]       count_sum;
    logic [COUNT_W-1:0]     diff;
    logic [INTER_W-1:0]     union_val;
    logic                   div_start, div_done;
    logic [FRACTION_BITS:0] sim;
    logic                   s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Popcount and saturating accumulate for one chunk of the word pair, reused for each chunk in turn.
    assign pc_and    = popcnt8(a_reg[CHUNK_BITS-1:0] & b_reg[CHUNK_BITS-1:0]);
    assign pc_a      = popcnt8(a_reg[CHUNK_BITS-1:0]);
    assign pc_b      = popcnt8(b_reg[CHUNK_BITS-1:0]);
    assign inter_sum = {1'b0, inter_reg} + (INTER_W + 1)'(pc_and);
    assign count_sum = {1'b0, count_reg} + (COUNT_W + 1)'(pc_a) + (COUNT_W + 1)'(pc_b);
    assign inter_next = (inter_sum > INTER_LIM) ? INTER_LIM[INTER_W-1:0]
                                                : inter_sum[INTER_W-1:0];
    assign count_next = (count_sum > COUNT_LIM) ? COUNT_LIM[COUNT_W-1:0]
                                                : count_sum[COUNT_W-1:0];

    // Union from the totals, zero if the count total somehow falls short, capped at the intersection limit.
    assign diff = (count_reg >= COUNT_W'(inter_reg)) ? count_reg - COUNT_W'(inter_reg) : '0;
    assign union_val = ((COUNT_W + 1)'(diff) > (COUNT_W + 1)'(INTER_LIM))
                     ? INTER_LIM[INTER_W-1:0] : INTER_W'(diff);

    assign div_start = (state_reg == ST_START);

    bjs_div #(
        .W    (INTER_W),
        .FRAC (FRACTION_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (inter_reg),
        .den      (union_reg),
        .done     (div_done),
        .quotient (sim)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (chunk_reg == CHUNK_CW'(CHUNKS - 1)) begin
                    state_next = last_reg ? ST_UNION : ST_IDLE;
                end
            end
            ST_UNION: state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            inter_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // A new result may replace one that is taken in the same cycle.
            if (state_reg == ST_OUT) begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_reg <= 1'b1;
                end
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        a_reg     <= s_tdata[WORD_W-1:0] & WORD_MASK;
                        b_reg     <= s_tdata[2*WORD_W-1:WORD_W] & WORD_MASK;
                        last_reg  <= s_tlast;
                        chunk_reg <= '0;
                    end
                end
                ST_COUNT: begin
                    inter_reg <= inter_next;
                    count_reg <= count_next;
                    a_reg     <= a_reg >> CHUNK_BITS;
                    b_reg     <= b_reg >> CHUNK_BITS;
                    chunk_reg <= chunk_reg + 1'b1;
                end
                ST_UNION: union_reg <= union_val;
                ST_START, ST_DIV: ;
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= OUT_TDATA_W'({sim, union_reg, inter_reg});
                        inter_reg    <= '0;
                        count_reg    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/bjs_checker.sv]
// Port-level checker for the Jaccard similarity block, bound to the top level.
// Depends on bjs_pkg for the bus widths and parameter defaults.
module bjs_checker
    import bjs_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEF,
    parameter int MAX_WORDS     = MAX_WORDS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int unsigned INTER_MAX = MAX_WORDS * WORD_BITS,
    localparam int INTER_W     = $clog2(INTER_MAX + 1),
    localparam int SIM_W       = FRACTION_BITS + 1,
    localparam int OUT_BITS    = 2 * INTER_W + SIM_W,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [2*WORD_W-1:0]    s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic [INTER_W-1:0] INTER_LIM = INTER_W'(INTER_MAX);
    localparam logic [SIM_W-1:0]   SIM_ONE   = {1'b1, {FRACTION_BITS{1'b0}}};

    // A held result keeps its data until the transaction completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Each word pair keeps the popcount unit busy, so s_tready drops once the pair is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while popcount unit busy");

    // A new result is only loaded from the output state, never while idle.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without finishing a set pair");

    // Counts stay within the saturation bound and the ratio within one.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[INTER_W-1:0] <= INTER_LIM)
                  && (m_tdata[INTER_W +: INTER_W] <= INTER_LIM)
                  && (m_tdata[2*INTER_W +: SIM_W] <= SIM_ONE))
        else $error("result field out of range");

    // Input data and last flag are not checked; they are connected for completeness of the port view.
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tlast};

endmodule

bind bitmask_jaccard_similarity_top bjs_checker #(
    .WORD_BITS     (WORD_BITS),
    .MAX_WORDS     (MAX_WORDS),
    .FRACTION_BITS (FRACTION_BITS)
) u_bjs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
